// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks used by the display controller RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check expr at every rising clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check cons in the same cycle as ante.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: sv/ssd_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment display package
// Widths, request codes, register indexes, segment tables and the control
// structs between the sequencer and the decimal conversion unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssd_pkg;

  localparam int MAX_DIGITS = 8;
  localparam int DIGIT_W    = $clog2(MAX_DIGITS);
  localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);
  localparam int NUM_BITS   = 32;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_BITS   = 4 * BCD_DIGITS;
  localparam int CONV_CNT_W = $clog2(NUM_BITS + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DUTY_SLOTS = 10;

  // Request codes
  localparam logic [2:0] FUNC_REFRESH      = 3'd0;
  localparam logic [2:0] FUNC_TICK         = 3'd1;
  localparam logic [2:0] FUNC_WRITE_NUMBER = 3'd2;
  localparam logic [2:0] FUNC_WRITE_CHAR   = 3'd3;
  localparam logic [2:0] FUNC_CLEAR        = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEADING_ZEROS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DP_POS         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COMMON_ANODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_INTERVAL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ENABLE = 3'd6;

  localparam logic [7:0] SEG_POINT = 8'h80;

  typedef struct packed {
    logic start;
    logic shift_out;
  } ssd_conv_ctrl_t;

  typedef struct packed {
    logic       busy;
    logic [3:0] digit;
    logic       rest_zero;
  } ssd_conv_stat_t;

  function automatic logic [7:0] ssd_digit_seg(input logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'h3F;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5B;
      4'd3:    p = 8'h4F;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6D;
      4'd6:    p = 8'h7D;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h6F;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] ssd_char_seg(input logic [7:0] c);
    logic [7:0] p;
    case (c) inside
      [8'h30:8'h39]: p = ssd_digit_seg(c[3:0]);
      8'h48: p = 8'h76;  // H
      8'h45: p = 8'h79;  // E
      8'h4C: p = 8'h38;  // L
      8'h50: p = 8'h73;  // P
      8'h4F: p = 8'h3F;  // O
      8'h41: p = 8'h77;  // A
      8'h43: p = 8'h39;  // C
      8'h55: p = 8'h3E;  // U
      8'h53: p = 8'h6D;  // S
      8'h46: p = 8'h71;  // F
      8'h47: p = 8'h3D;  // G
      8'h4A: p = 8'h1E;  // J
      8'h59: p = 8'h6E;  // Y
      8'h74: p = 8'h78;  // t
      8'h72: p = 8'h50;  // r
      8'h62: p = 8'h7C;  // b
      8'h6E: p = 8'h54;  // n
      8'h64: p = 8'h5E;  // d
      8'h69: p = 8'h04;  // i
      8'h6F: p = 8'h5C;  // o
      8'h75: p = 8'h1C;  // u
      8'h2D: p = 8'h40;  // -
      8'h5F: p = 8'h08;  // _
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  // Lit slots per ten-slot frame: saturated percent / 10
  function automatic logic [3:0] ssd_duty_limit(input logic [6:0] pct);
    logic [6:0] v;
    logic [3:0] n;
    v = (pct > 7'd100) ? 7'd100 : pct;
    n = 4'd0;
    for (int t = 1; t <= DUTY_SLOTS; t++) begin
      if (v >= 7'(10 * t)) begin
        n = n + 4'd1;
      end
    end
    return n;
  endfunction

endpackage

// File: sv/ssd_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one display request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ssd_req_if;
  import ssd_pkg::*;

  logic                valid;
  logic                ready;
  logic [2:0]          func;
  logic [NUM_BITS-1:0] number;
  logic [DIGIT_W-1:0]  position;
  logic [7:0]          char_code;

  modport source (output valid, func, number, position, char_code, input ready);
  modport sink   (input valid, func, number, position, char_code, output ready);
endinterface

// File: sv/ssd_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the segment and common pin levels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ssd_rsp_if;
  import ssd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [7:0]            segment_levels;
  logic [MAX_DIGITS-1:0] common_levels;

  modport source (output valid, segment_levels, common_levels, input ready);
  modport sink   (input valid, segment_levels, common_levels, output ready);
endinterface

// File: sv/ssd_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ssd_cfg_if;
  import ssd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/seven_segment_mux_display_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiplexed seven-segment display controller
// Holds one segment pattern per digit and scans them on refresh requests.
// ----------------------------------------------------------------------------
// Every request gives one response with the segment and common pin levels.
// Refresh, tick, write-character, clear and unknown requests are done in the
// cycle they are taken; the response is loaded from the finish state once the
// output register is free, and the request port opens again with that load.
// A write-number request runs through the binary-to-decimal unit, one bit
// a cycle, then stores one digit a cycle. The request port is closed while
// a request is in progress; a response waiting in the output register does
// not hold off the next request. Register writes are taken only while the
// block is idle and no request is offered. All digit patterns clear on reset
// and no sweep follows it.
// ----------------------------------------------------------------------------

`include "assert_macros.svh"

module seven_segment_mux_display_unit (
  input logic   clk,
  input logic   rst,
  ssd_cfg_if.sink    cfg,
  ssd_req_if.sink    req,
  ssd_rsp_if.source  rsp
);
  import ssd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONVERT,
    S_WRITE,
    S_FINISH
  } state_t;

  state_t state;

  // Configuration
  logic [COUNT_W-1:0] digit_count;
  logic [3:0]         duty_limit;
  logic               leading_zeros;
  logic [3:0]         decimal_point_pos;
  logic               common_anode;
  logic [15:0]        flash_interval;
  logic               display_enable;

  // Display state
  logic [7:0]            digit_patterns [MAX_DIGITS];
  logic [DIGIT_W-1:0]    scan_digit;
  logic [3:0]            duty_slot;
  logic                  flash_visible;
  logic [15:0]           flash_elapsed;
  logic [7:0]            shown_pattern;
  logic [MAX_DIGITS-1:0] lit_digit_mask;

  logic [DIGIT_W-1:0]    wr_pos;
  logic                  rsp_valid;
  logic [7:0]            rsp_seg;
  logic [MAX_DIGITS-1:0] rsp_com;

  ssd_conv_ctrl_t conv_ctrl;
  ssd_conv_stat_t conv_stat;

  logic               req_fire;
  logic               lit;
  logic [DIGIT_W-1:0] scan_idx;
  logic [COUNT_W-1:0] scan_inc;
  logic [DIGIT_W-1:0] scan_next;
  logic [3:0]         duty_next;
  logic [15:0]        elapsed_inc;
  logic [COUNT_W-1:0] wr_idx_full;
  logic [DIGIT_W-1:0] wr_idx;
  logic               wr_last;
  logic [7:0]         wr_pat;
  logic               out_free;
  logic [3:0]         cfg_count;

  assign req_fire  = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  // Hold register writes while a request is offered or in progress
  assign cfg.ready = (state == S_IDLE) && !req.valid;
  assign out_free  = !rsp_valid || rsp.ready;

  assign conv_ctrl.start     = req_fire && (req.func == FUNC_WRITE_NUMBER);
  assign conv_ctrl.shift_out = (state == S_WRITE);

  ssd_bcd_conv u_conv (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (conv_ctrl),
    .value (req.number),
    .stat  (conv_stat)
  );

  always_comb begin
    lit = display_enable && flash_visible && (duty_slot < duty_limit);
    // Restart the scan when it sits at or beyond the digit count
    scan_idx  = ({1'b0, scan_digit} >= digit_count) ? '0 : scan_digit;
    scan_inc  = {1'b0, scan_idx} + COUNT_W'(1);
    scan_next = (scan_inc == digit_count) ? '0 : scan_inc[DIGIT_W-1:0];
    duty_next = (duty_slot == 4'(DUTY_SLOTS - 1)) ? 4'd0 : duty_slot + 4'd1;
    elapsed_inc = flash_elapsed + 16'd1;

    // wr_pos counts digits from the right
    wr_idx_full = digit_count - COUNT_W'(1) - {1'b0, wr_pos};
    wr_idx      = wr_idx_full[DIGIT_W-1:0];
    wr_last     = ({1'b0, wr_pos} == digit_count - COUNT_W'(1));
    if (conv_stat.rest_zero && (wr_pos != '0) && !leading_zeros) begin
      wr_pat = 8'h00;
    end else begin
      wr_pat = ssd_digit_seg(conv_stat.digit);
    end
    if (decimal_point_pos == {1'b0, wr_pos} + 4'd1) begin
      wr_pat = wr_pat | SEG_POINT;
    end

    // Saturate the digit count into 1..MAX_DIGITS
    if (cfg.data[3:0] == 4'd0) begin
      cfg_count = 4'd1;
    end else if (cfg.data[3:0] > 4'(MAX_DIGITS)) begin
      cfg_count = 4'(MAX_DIGITS);
    end else begin
      cfg_count = cfg.data[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      digit_count       <= COUNT_W'(MAX_DIGITS);
      duty_limit        <= 4'(DUTY_SLOTS);
      leading_zeros     <= 1'b0;
      decimal_point_pos <= 4'd0;
      common_anode      <= 1'b0;
      flash_interval    <= 16'd0;
      display_enable    <= 1'b1;
      for (int d = 0; d < MAX_DIGITS; d++) begin
        digit_patterns[d] <= 8'h00;
      end
      scan_digit        <= '0;
      duty_slot         <= 4'd0;
      flash_visible     <= 1'b1;
      flash_elapsed     <= 16'd0;
      shown_pattern     <= 8'h00;
      lit_digit_mask    <= '0;
      wr_pos            <= '0;
      rsp_valid         <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            state <= (req.func == FUNC_WRITE_NUMBER) ? S_CONVERT : S_FINISH;
            case (req.func)
              FUNC_REFRESH: begin
                duty_slot <= duty_next;
                if (lit) begin
                  shown_pattern  <= digit_patterns[scan_idx];
                  lit_digit_mask <= MAX_DIGITS'(1) << scan_idx;
                  scan_digit     <= scan_next;
                end else begin
                  lit_digit_mask <= '0;
                end
              end
              FUNC_TICK: begin
                if (flash_interval != 16'd0) begin
                  if (elapsed_inc >= flash_interval) begin
                    flash_elapsed <= 16'd0;
                    flash_visible <= !flash_visible;
                  end else begin
                    flash_elapsed <= elapsed_inc;
                  end
                end
              end
              FUNC_WRITE_NUMBER: begin
                wr_pos <= '0;
              end
              FUNC_WRITE_CHAR: begin
                if ({1'b0, req.position} < digit_count) begin
                  digit_patterns[req.position] <= ssd_char_seg(req.char_code);
                end
              end
              FUNC_CLEAR: begin
                for (int d = 0; d < MAX_DIGITS; d++) begin
                  digit_patterns[d] <= 8'h00;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CONVERT: begin
          if (!conv_stat.busy) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          digit_patterns[wr_idx] <= wr_pat;
          wr_pos                 <= wr_pos + DIGIT_W'(1);
          if (wr_last) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // Hold until the output register is free
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (state == S_FINISH && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_DIGIT_COUNT:    digit_count       <= cfg_count[COUNT_W-1:0];
          REG_BRIGHTNESS:     duty_limit        <= ssd_duty_limit(cfg.data[6:0]);
          REG_LEADING_ZEROS:  leading_zeros     <= cfg.data[0];
          REG_DP_POS:         decimal_point_pos <= cfg.data[3:0];
          REG_COMMON_ANODE:   common_anode      <= cfg.data[0];
          REG_FLASH_INTERVAL: begin
            flash_interval <= cfg.data;
            flash_elapsed  <= 16'd0;
            if (cfg.data == 16'd0) begin
              flash_visible <= 1'b1;
            end
          end
          REG_DISPLAY_ENABLE: display_enable    <= cfg.data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Response payload, polarity applied at load
  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      rsp_seg <= shown_pattern ^ {8{common_anode}};
      rsp_com <= lit_digit_mask ^ {MAX_DIGITS{common_anode}};
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.segment_levels = rsp_seg;
  assign rsp.common_levels  = rsp_com;

  `ASSERT_ALWAYS(a_one_common_lit, clk, rst, $onehot0(lit_digit_mask), "more than one common lit")
  `ASSERT_ALWAYS(a_duty_range, clk, rst, duty_slot < 4'(DUTY_SLOTS), "duty slot out of range")
  `ASSERT_IMPLIES(a_write_after_conv, clk, rst, state == S_WRITE, !conv_stat.busy, "digit store during conversion")
  `ASSERT_NEXT(a_short_request, clk, rst, req_fire && req.func != FUNC_WRITE_NUMBER, state == S_FINISH, "short request not finished")

endmodule

// File: sv/ssd_bcd_conv.sv
// ----------------------------------------------------------------------------
// Binary to decimal converter
// Shift-and-add-3 unit: one binary bit per cycle into a ten-digit BCD
// register, then hands the digits out least significant first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssd_bcd_conv (
  input  logic                    clk,
  input  logic                    rst,
  input  ssd_pkg::ssd_conv_ctrl_t ctrl,
  input  logic [31:0]             value,
  output ssd_pkg::ssd_conv_stat_t stat
);
  import ssd_pkg::*;

  logic [NUM_BITS-1:0]   bin;
  logic [BCD_BITS-1:0]   bcd;
  logic [BCD_BITS-1:0]   bcd_adj;
  logic [CONV_CNT_W-1:0] cnt;

  // Add 3 to every digit of five or more before the shift
  always_comb begin
    bcd_adj = bcd;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.start) begin
      cnt <= CONV_CNT_W'(NUM_BITS);
    end else if (cnt != '0) begin
      cnt <= cnt - CONV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      bin <= value;
      bcd <= '0;
    end else if (cnt != '0) begin
      bcd <= {bcd_adj[BCD_BITS-2:0], bin[NUM_BITS-1]};
      bin <= {bin[NUM_BITS-2:0], 1'b0};
    end else if (ctrl.shift_out) begin
      bcd <= {4'd0, bcd[BCD_BITS-1:4]};
    end
  end

  assign stat.busy      = (cnt != '0);
  assign stat.digit     = bcd[3:0];
  assign stat.rest_zero = (bcd == '0);

endmodule
